// File: hw/rtl/pjq_pkg.sv
// Package for the priority job queue: field widths, default parameters,
// operation and status codes, and the controller command and state types.
// No dependencies.
package pjq_pkg;

    // Fixed widths of the item fields.
    localparam int HANDLE_W    = 32;
    localparam int FIELD_PRI_W = 16;

    // Default parameter values for the top level.
    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_PRIORITY_BITS = 16;

    // Operation codes of an input item.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } t_op;

    // Status codes of a result item.
    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_FULL   = 2'd1,
        ST_PULLED = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input item and the compare vector
        logic execute;   // update the cell row and load the result register
    } t_cmd;

endpackage

// File: hw/rtl/pjq_if.sv
// Handshake interfaces for the job channel and the result channel.
// Depends on pjq_pkg.

// Job channel: one push or pull request per transfer.
interface pjq_job_if;
    import pjq_pkg::*;

    logic                           valid;
    logic                           ready;
    t_op                            operation;
    logic        [HANDLE_W-1:0]     job_handle;
    logic signed [FIELD_PRI_W-1:0]  job_priority;
    logic                           has_priority;

    modport source (
        output valid, operation, job_handle, job_priority, has_priority,
        input  ready
    );
    modport sink (
        input  valid, operation, job_handle, job_priority, has_priority,
        output ready
    );
endinterface

// Result channel: one result per transfer.
interface pjq_res_if #(
    parameter int LEN_W = 5
);
    import pjq_pkg::*;

    logic                           valid;
    logic                           ready;
    t_status                        status;
    logic        [HANDLE_W-1:0]     pulled_handle;
    logic signed [FIELD_PRI_W-1:0]  pulled_priority;
    logic                           pulled_has_priority;
    logic        [LEN_W-1:0]        queue_length;

    modport source (
        output valid, status, pulled_handle, pulled_priority,
               pulled_has_priority, queue_length,
        input  ready
    );
    modport sink (
        input  valid, status, pulled_handle, pulled_priority,
               pulled_has_priority, queue_length,
        output ready
    );
endinterface

// File: hw/rtl/pjq_ctrl.sv
// Controller for the priority job queue: sequences capture and execute
// steps and owns the handshakes of both channels.
// Depends on pjq_pkg.
module pjq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pjq_pkg::t_cmd o_cmd
);
    import pjq_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands. An item is taken in idle even while an
    // older result still waits; execution waits for the result register.
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid & ~i_out_ready;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/pjq_datapath.sv
// Datapath for the priority job queue: the shift-register row of queue
// cells, the parallel priority compare and the result register.
// Depends on pjq_pkg.
module pjq_datapath #(
    parameter int QUEUE_DEPTH   = pjq_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = pjq_pkg::DEF_PRIORITY_BITS,
    parameter int LEN_W         = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pjq_pkg::t_cmd                         i_cmd,
    input  pjq_pkg::t_op                          i_operation,
    input  logic        [pjq_pkg::HANDLE_W-1:0]    i_job_handle,
    input  logic signed [pjq_pkg::FIELD_PRI_W-1:0] i_job_priority,
    input  logic                                  i_has_priority,
    output pjq_pkg::t_status                      o_status,
    output logic        [pjq_pkg::HANDLE_W-1:0]    o_pulled_handle,
    output logic signed [pjq_pkg::FIELD_PRI_W-1:0] o_pulled_priority,
    output logic                                  o_pulled_has_priority,
    output logic        [LEN_W-1:0]               o_queue_length
);
    import pjq_pkg::*;

    localparam int D      = QUEUE_DEPTH;
    localparam int PB     = PRIORITY_BITS;
    localparam int WIDE_W = (PB > FIELD_PRI_W) ? PB : FIELD_PRI_W;

    // Queue cells; cell 0 is the front.
    logic        [HANDLE_W-1:0] r_hdl [D];
    logic signed [PB-1:0]       r_pri [D];
    logic                       r_has [D];
    logic        [HANDLE_W-1:0] n_hdl [D];
    logic signed [PB-1:0]       n_pri [D];
    logic                       n_has [D];

    // Occupancy: thermometer of valid cells and the entry count.
    logic [D-1:0]     r_valid, n_valid;
    logic [LEN_W-1:0] r_count, n_count;

    // Captured item and compare vector.
    t_op                  r_op;
    logic [HANDLE_W-1:0]  r_in_hdl;
    logic signed [PB-1:0] r_in_pri;
    logic                 r_in_has;
    logic [D-1:0]         r_match;

    // Result register.
    t_status                        r_o_status;
    logic        [HANDLE_W-1:0]     r_o_hdl;
    logic signed [FIELD_PRI_W-1:0]  r_o_pri;
    logic                           r_o_has;
    logic        [LEN_W-1:0]        r_o_len;

    logic [WIDE_W-1:0]    w_in_wide;
    logic signed [PB-1:0] w_in_pri;
    logic [D-1:0]         w_match;
    logic [D-1:0]         w_neg;
    logic [D-1:0]         w_first;
    logic [D-1:0]         w_ge;
    logic [D-1:0]         w_tail;
    logic [D-1:0]         w_load;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_do_push;
    logic                 w_do_pull;
    logic [WIDE_W-1:0]    w_out_wide;

    // Input priority read as a PRIORITY_BITS two's complement value.
    assign w_in_wide = WIDE_W'($unsigned(i_job_priority));
    assign w_in_pri  = i_has_priority ? signed'(w_in_wide[PB-1:0]) : '0;

    // Each occupied prioritized cell compares its priority with the new one.
    always_comb begin
        for (int i = 0; i < D; i++) begin
            w_match[i] = i_has_priority & r_valid[i] & r_has[i] & (r_pri[i] < w_in_pri);
        end
    end

    // Capture stage.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_in_hdl <= i_job_handle;
            r_in_pri <= w_in_pri;
            r_in_has <= i_has_priority;
            r_match  <= w_match;
        end
    end

    // Insert position: the lowest matching cell, or the first free cell.
    // The cells from the insert position upward all move one place back.
    assign w_neg     = ~r_match + D'(1);
    assign w_first   = r_match & w_neg;
    assign w_ge      = r_match | w_neg;
    assign w_tail    = ~r_valid & {r_valid[D-2:0], 1'b1};
    assign w_load    = (r_match != '0) ? w_first : w_tail;
    assign w_full    = r_valid[D-1];
    assign w_empty   = ~r_valid[0];
    assign w_do_push = i_cmd.execute & (r_op == OP_PUSH) & ~w_full;
    assign w_do_pull = i_cmd.execute & (r_op == OP_PULL) & ~w_empty;

    // Next value of every cell.
    always_comb begin
        for (int i = 0; i < D; i++) begin
            n_hdl[i] = r_hdl[i];
            n_pri[i] = r_pri[i];
            n_has[i] = r_has[i];
            if (w_do_push) begin
                if (w_load[i]) begin
                    n_hdl[i] = r_in_hdl;
                    n_pri[i] = r_in_pri;
                    n_has[i] = r_in_has;
                end else if (i > 0 && w_ge[(i > 0) ? i - 1 : 0]) begin
                    n_hdl[i] = r_hdl[(i > 0) ? i - 1 : 0];
                    n_pri[i] = r_pri[(i > 0) ? i - 1 : 0];
                    n_has[i] = r_has[(i > 0) ? i - 1 : 0];
                end
            end else if (w_do_pull && i < D - 1) begin
                n_hdl[i] = r_hdl[(i < D - 1) ? i + 1 : i];
                n_pri[i] = r_pri[(i < D - 1) ? i + 1 : i];
                n_has[i] = r_has[(i < D - 1) ? i + 1 : i];
            end
        end
    end

    // Cell row.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < D; i++) begin
            r_hdl[i] <= n_hdl[i];
            r_pri[i] <= n_pri[i];
            r_has[i] <= n_has[i];
        end
    end

    // Occupancy update.
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        if (w_do_push) begin
            n_valid = {r_valid[D-2:0], 1'b1};
            n_count = r_count + LEN_W'(1);
        end else if (w_do_pull) begin
            n_valid = {1'b0, r_valid[D-1:1]};
            n_count = r_count - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    // Front priority zero-extended from PRIORITY_BITS into the result field.
    assign w_out_wide = WIDE_W'($unsigned(r_pri[0]));

    // Result register, loaded as the operation is carried out.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_o_hdl <= '0;
            r_o_pri <= '0;
            r_o_has <= 1'b0;
            r_o_len <= n_count;
            if (r_op == OP_PUSH) begin
                r_o_status <= w_full ? ST_FULL : ST_PUSHED;
            end else if (w_empty) begin
                r_o_status <= ST_EMPTY;
            end else begin
                r_o_status <= ST_PULLED;
                r_o_hdl    <= r_hdl[0];
                r_o_pri    <= signed'(w_out_wide[FIELD_PRI_W-1:0]);
                r_o_has    <= r_has[0];
            end
        end
    end

    assign o_status              = r_o_status;
    assign o_pulled_handle       = r_o_hdl;
    assign o_pulled_priority     = r_o_pri;
    assign o_pulled_has_priority = r_o_has;
    assign o_queue_length        = r_o_len;

endmodule

// File: hw/rtl/priority_job_queue.sv
// Priority job queue. Each job runs a capture and compare step, then the
// update step of the single cell row, which loads the result register; the
// next job is taken only once the update step of the last one is done.
// A result held by a stalled sink delays the update step until it is taken.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; the cell contents are not cleared.
module priority_job_queue #(
    parameter int QUEUE_DEPTH   = pjq_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = pjq_pkg::DEF_PRIORITY_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pjq_job_if.sink   i_job,
    pjq_res_if.source o_res
);
    import pjq_pkg::*;

    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd w_cmd;
    logic w_in_ready;
    logic w_out_valid;

    // Handshake sequencing.
    pjq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_job.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd)
    );

    // Cell row and result register.
    pjq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .LEN_W         (LEN_W)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .i_operation           (i_job.operation),
        .i_job_handle          (i_job.job_handle),
        .i_job_priority        (i_job.job_priority),
        .i_has_priority        (i_job.has_priority),
        .o_status              (o_res.status),
        .o_pulled_handle       (o_res.pulled_handle),
        .o_pulled_priority     (o_res.pulled_priority),
        .o_pulled_has_priority (o_res.pulled_has_priority),
        .o_queue_length        (o_res.queue_length)
    );

    assign i_job.ready = w_in_ready;
    assign o_res.valid = w_out_valid;

endmodule

// File: test/priority_job_queue_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for priority_job_queue: random push and pull jobs with
// random idling on both channels, checked against a sorted-insert queue model.
// Depends on pjq_pkg, pjq_if and the priority_job_queue RTL.
module priority_job_queue_test;
    import pjq_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int PRIO_BITS   = DEF_PRIORITY_BITS;
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int RANDOM_JOBS = 1750;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 10;

    // One queued job as the model holds it.
    typedef struct packed {
        logic [HANDLE_W-1:0]           handle;
        logic signed [FIELD_PRI_W-1:0] prio;
        logic                          has;
    } t_queued_job;

    // One result as the block presents it.
    typedef struct packed {
        t_status                       status;
        logic [HANDLE_W-1:0]           handle;
        logic signed [FIELD_PRI_W-1:0] prio;
        logic                          has;
        logic [LEN_W-1:0]              length;
    } t_job_result;

    // Model of the sorted queue and the results it must produce.
    class job_queue_scoreboard;
        t_queued_job queued[$];
        t_job_result awaited[$];
        int          errors = 0;

        // Apply one accepted job to the model and queue the result it causes.
        function void note_job(t_op op, logic [HANDLE_W-1:0] handle,
                               logic signed [FIELD_PRI_W-1:0] prio, logic has);
            t_job_result res;
            t_queued_job job;
            int          pos;
            res = '0;
            if (op == OP_PUSH) begin
                if (queued.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    job.handle = handle;
                    job.has    = has;
                    // Only the low priority bits count, sign-extended.
                    job.prio   = has ? ($signed(prio <<< (FIELD_PRI_W - PRIO_BITS))
                                        >>> (FIELD_PRI_W - PRIO_BITS)) : '0;
                    pos = queued.size();
                    if (has) begin
                        for (int i = 0; i < queued.size(); i++) begin
                            if (queued[i].has && queued[i].prio < job.prio) begin
                                pos = i;
                                break;
                            end
                        end
                    end
                    queued.insert(pos, job);
                    res.status = ST_PUSHED;
                end
            end else begin
                if (queued.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    job        = queued.pop_front();
                    res.status = ST_PULLED;
                    res.handle = job.handle;
                    res.prio   = job.prio;
                    res.has    = job.has;
                end
            end
            res.length = LEN_W'(queued.size());
            awaited.push_back(res);
        endfunction

        // Compare one accepted result with the oldest awaited one.
        function void check_result(t_job_result got);
            t_job_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, status %0d length %0d",
                         $time, got.status, got.length);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status,
                         got.status);
                errors++;
            end
            if (got.handle !== want.handle) begin
                $display("%0t: pulled_handle expected %h actual %h", $time, want.handle,
                         got.handle);
                errors++;
            end
            if (got.prio !== want.prio) begin
                $display("%0t: pulled_priority expected %0d actual %0d", $time,
                         want.prio, got.prio);
                errors++;
            end
            if (got.has !== want.has) begin
                $display("%0t: pulled_has_priority expected %b actual %b", $time,
                         want.has, got.has);
                errors++;
            end
            if (got.length !== want.length) begin
                $display("%0t: queue_length expected %0d actual %0d", $time,
                         want.length, got.length);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   src_steady = 1'b0;
    bit   snk_steady = 1'b0;
    int   idle_cycles = 0;
    job_queue_scoreboard sb = new();

    pjq_job_if job_if ();
    pjq_res_if #(.LEN_W(LEN_W)) res_if ();

    priority_job_queue #(
        .QUEUE_DEPTH   (DEPTH),
        .PRIORITY_BITS (PRIO_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_if),
        .o_res   (res_if)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Send one job, waiting a random gap first and then for its transfer.
    task automatic send_job(input t_op op, input logic [HANDLE_W-1:0] handle,
                            input logic signed [FIELD_PRI_W-1:0] prio, input logic has);
        int gap;
        if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            job_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        job_if.valid        <= 1'b1;
        job_if.operation    <= op;
        job_if.job_handle   <= handle;
        job_if.job_priority <= prio;
        job_if.has_priority <= has;
        @(posedge i_clk);
        while (!job_if.ready) @(posedge i_clk);
        sb.note_job(op, handle, prio, has);
    endtask

    // Pick a priority that often ties or hits the extremes.
    function automatic logic signed [FIELD_PRI_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0:       return FIELD_PRI_W'($signed(FIELD_PRI_W'($urandom_range(0, 4))) - 2);
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return FIELD_PRI_W'($urandom());
        endcase
    endfunction

    // Result side: random stalls, then check each transfer.
    initial begin : result_sink
        int          stall;
        t_job_result got;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) snk_steady = !snk_steady;
            stall = snk_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            got.status = res_if.status;
            got.handle = res_if.pulled_handle;
            got.prio   = res_if.pulled_priority;
            got.has    = res_if.pulled_has_priority;
            got.length = res_if.queue_length;
            sb.check_result(got);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((job_if.valid && job_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus: reset, directed jobs, then random phases.
    initial begin : job_source
        int  sent;
        int  phase_len;
        int  pull_pct;
        t_op op;
        i_rst_n             <= 1'b0;
        job_if.valid        <= 1'b0;
        job_if.operation    <= OP_PUSH;
        job_if.job_handle   <= '0;
        job_if.job_priority <= '0;
        job_if.has_priority <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pull on an empty queue, then a mix of extremes and ties.
        send_job(OP_PULL, 32'hFFFF_FFFF, 16'sh7FFF, 1'b1);
        send_job(OP_PUSH, 32'h0000_0000, 16'sh7FFF, 1'b0);
        send_job(OP_PUSH, 32'hFFFF_FFFF, 16'sh0000, 1'b1);
        send_job(OP_PUSH, 32'h1111_1111, 16'sh7FFF, 1'b1);
        send_job(OP_PUSH, 32'h2222_2222, 16'sh8000, 1'b1);
        send_job(OP_PUSH, 32'h3333_3333, -16'sd1, 1'b1);
        send_job(OP_PUSH, 32'h4444_4444, -16'sd1, 1'b1);
        send_job(OP_PUSH, 32'h5555_5555, 16'sh8000, 1'b0);
        send_job(OP_PUSH, 32'h6666_6666, 16'sh7FFF, 1'b1);
        send_job(OP_PUSH, 32'hAAAA_AAAA, 16'sd1, 1'b1);
        repeat (10) send_job(OP_PULL, '0, '0, 1'b0);

        // Random phases that lean toward filling, draining, or neither.
        sent = 0;
        while (sent < RANDOM_JOBS) begin
            case ($urandom_range(0, 2))
                0:       pull_pct = 15;
                1:       pull_pct = 85;
                default: pull_pct = 50;
            endcase
            phase_len = $urandom_range(20, 80);
            repeat (phase_len) begin
                op = ($urandom_range(0, 99) < pull_pct) ? OP_PULL : OP_PUSH;
                send_job(op, $urandom(), pick_priority(), $urandom_range(0, 3) != 0);
                sent++;
            end
        end
        job_if.valid <= 1'b0;

        // Wait for the last results and a drain wait, then report the outcome.
        while (sb.awaited.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/pjq_pkg.sv
hw/rtl/pjq_if.sv
hw/rtl/pjq_ctrl.sv
hw/rtl/pjq_datapath.sv
hw/rtl/priority_job_queue.sv
test/priority_job_queue_test.sv
